// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the sorted set block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SISI_ASSERT(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// Concurrent assertion on the local clk and arst_n signals.
`define SISI_CHECK(lbl, prop, msg) `SISI_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// ===== design/sisi_pkg.sv =====
// Package with the types and codes of the sorted integer set block.
package sisi_pkg;

	localparam int VAL_W = 16;
	localparam int CNT_W = 7;
	localparam int STAT_W = 3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DUMP   = 1'b1;

	localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
	localparam logic [STAT_W-1:0] ST_ELEMENT  = 3'd4;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	typedef struct packed {
		logic             insert;
		logic             rotate;
		logic [VAL_W-1:0] key;
	} cell_ctl_t;

endpackage

// ===== design/sisi_if.sv =====
// Request and response channel interfaces of the sorted integer set block.
interface sisi_req_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [sisi_pkg::VAL_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

interface sisi_resp_if;
	logic                        valid;
	logic                        ready;
	logic [sisi_pkg::STAT_W-1:0] status;
	logic [sisi_pkg::VAL_W-1:0]  element;
	logic [sisi_pkg::CNT_W-1:0]  position;
	logic [sisi_pkg::CNT_W-1:0]  count;
	logic                        last;

	modport source (output valid, output status, output element, output position,
		output count, output last, input ready);
	modport sink (input valid, input status, input element, input position,
		input count, input last, output ready);
endinterface

// ===== design/sisi_cell.sv =====
// One storage cell of the sorted chain: compares, shifts up on insert, rotates on dump.
module sisi_cell (
	input  logic                        clk,
	input  sisi_pkg::cell_ctl_t         ctl,
	input  logic                        occupied,
	input  logic                        place,
	input  logic                        wrap,
	input  logic [sisi_pkg::VAL_W-1:0]  left_value,
	input  logic [sisi_pkg::VAL_W-1:0]  right_value,
	input  logic [sisi_pkg::VAL_W-1:0]  head_value,
	output logic [sisi_pkg::VAL_W-1:0]  value_q,
	output logic                        lt,
	output logic                        eq
);

	assign lt = occupied && (value_q < ctl.key);
	assign eq = occupied && (value_q == ctl.key);

	always_ff @(posedge clk) begin
		if (ctl.insert && !lt) begin
			value_q <= place ? ctl.key : left_value;
		end else if (ctl.rotate) begin
			value_q <= wrap ? head_value : right_value;
		end
	end

endmodule

// ===== design/sorted_integer_set_insert.sv =====
// Top level of the sorted integer set: a chain of compare-and-shift cells.
//
// The req channel carries requests: opcode 0 inserts value, opcode 1 dumps the set.
// The resp channel returns results through a single output register; an item is
// moved on either channel when valid and ready are both high.
// On an insert every cell compares in parallel, the cell at the insert position
// takes the new value, the cells above it take their lower neighbor's value, and
// the result is registered at the same edge. One insert can be accepted every
// cycle when idle, and a dump rotates the chain and emits the head cell once per
// cycle, while the output register is free; an empty set gives one result at once.
// No request is accepted while a dump is streaming.
// The max_value register is written by cfg_we and cfg_wdata and resets to 65535.
// Reset empties the set and clears the output valid flag; cell contents are not reset.
// When the receiver stalls, the pending result holds and no new request or
// dump step proceeds until it is taken.
module sorted_integer_set_insert #(
	parameter int CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	sisi_req_if.sink                   req,
	sisi_resp_if.source                resp,
	input  logic                       cfg_we,
	input  logic [sisi_pkg::VAL_W-1:0] cfg_wdata
);

	localparam int CW = sisi_pkg::CNT_W;
	localparam int VW = sisi_pkg::VAL_W;

	sisi_pkg::state_t    state_q;
	sisi_pkg::state_t    state_next;
	sisi_pkg::cell_ctl_t ctl;

	logic [VW-1:0]       max_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [VW-1:0]       cell_val [CAPACITY];
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;
	logic [CAPACITY-1:0] first;
	logic [CW-1:0]       pos_enc;
	logic [CW-1:0]       position;
	logic                slot_free;
	logic                accept;
	logic                dump_start;
	logic                rotate;
	logic                dump_last;
	logic                out_range;
	logic                present;
	logic                full;
	logic                commit;
	logic [2:0]          ins_status;

	logic                out_valid_q;
	logic [2:0]          out_status_q;
	logic [VW-1:0]       out_element_q;
	logic [CW-1:0]       out_position_q;
	logic [CW-1:0]       out_count_q;
	logic                out_last_q;

	assign slot_free  = !out_valid_q || resp.ready;
	assign accept     = req.valid && req.ready;
	assign dump_start = accept && req.opcode == sisi_pkg::OP_DUMP && count_q != '0;
	assign dump_last  = (idx_q == count_q - CW'(1));

	always_comb begin
		req.ready = 1'b0;
		rotate    = 1'b0;
		case (state_q)
			sisi_pkg::S_IDLE: req.ready = slot_free;
			sisi_pkg::S_DUMP: rotate = slot_free;
			default: begin
				req.ready = 1'b0;
				rotate    = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			sisi_pkg::S_IDLE: begin
				if (dump_start) begin
					state_next = sisi_pkg::S_DUMP;
				end
			end
			sisi_pkg::S_DUMP: begin
				if (rotate && dump_last) begin
					state_next = sisi_pkg::S_IDLE;
				end
			end
			default: state_next = sisi_pkg::S_IDLE;
		endcase
	end

	assign out_range = req.value >= max_q;
	assign present   = |eq;
	assign full      = (count_q == CW'(CAPACITY));
	assign commit    = !out_range && !present && !full;

	always_comb begin
		if (out_range) begin
			ins_status = sisi_pkg::ST_RANGE;
		end else if (present) begin
			ins_status = sisi_pkg::ST_PRESENT;
		end else if (full) begin
			ins_status = sisi_pkg::ST_FULL;
		end else begin
			ins_status = sisi_pkg::ST_INSERTED;
		end
	end

	assign ctl.insert = accept && req.opcode == sisi_pkg::OP_INSERT && commit;
	assign ctl.rotate = rotate;
	assign ctl.key    = req.value;

	always_comb begin
		pos_enc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first[i]) begin
				pos_enc = pos_enc | CW'(i);
			end
		end
	end

	assign position = lt[CAPACITY-1] ? CW'(CAPACITY) : pos_enc;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VW-1:0] left_value;
		logic [VW-1:0] right_value;

		if (i == 0) begin : g_head
			assign left_value = ctl.key;
			assign first[i]   = !lt[i];
		end else begin : g_body
			assign left_value = cell_val[i-1];
			assign first[i]   = !lt[i] && lt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_value = cell_val[0];
		end else begin : g_mid
			assign right_value = cell_val[i+1];
		end

		sisi_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (CW'(i) < count_q),
			.place       (first[i]),
			.wrap        (CW'(i) == count_q - CW'(1)),
			.left_value  (left_value),
			.right_value (right_value),
			.head_value  (cell_val[0]),
			.value_q     (cell_val[i]),
			.lt          (lt[i]),
			.eq          (eq[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sisi_pkg::S_IDLE;
			max_q       <= '1;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (ctl.insert) begin
				count_q <= count_q + CW'(1);
			end
			if (accept) begin
				idx_q <= '0;
			end else if (rotate) begin
				idx_q <= idx_q + CW'(1);
			end
			if ((accept && !dump_start) || rotate) begin
				out_valid_q <= 1'b1;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !dump_start) begin
			if (req.opcode == sisi_pkg::OP_DUMP) begin
				out_status_q   <= sisi_pkg::ST_EMPTY;
				out_element_q  <= '0;
				out_position_q <= '0;
				out_count_q    <= '0;
			end else begin
				out_status_q   <= ins_status;
				out_element_q  <= req.value;
				out_position_q <= position;
				out_count_q    <= ctl.insert ? count_q + CW'(1) : count_q;
			end
			out_last_q <= 1'b1;
		end else if (rotate) begin
			out_status_q   <= sisi_pkg::ST_ELEMENT;
			out_element_q  <= cell_val[0];
			out_position_q <= idx_q;
			out_count_q    <= count_q;
			out_last_q     <= dump_last;
		end
	end

	assign resp.valid    = out_valid_q;
	assign resp.status   = out_status_q;
	assign resp.element  = out_element_q;
	assign resp.position = out_position_q;
	assign resp.count    = out_count_q;
	assign resp.last     = out_last_q;

endmodule

// ===== design/sisi_checker.sv =====
// Port-level checker for the sorted integer set, bound to the top level.
`include "assert_macros.svh"

module sisi_checker #(
	parameter int CAPACITY = 16
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        resp_valid,
	input logic                        resp_ready,
	input logic [sisi_pkg::STAT_W-1:0] resp_status,
	input logic [sisi_pkg::CNT_W-1:0]  resp_position,
	input logic [sisi_pkg::CNT_W-1:0]  resp_count,
	input logic                        resp_last
);

	`SISI_CHECK(a_resp_hold, resp_valid && !resp_ready |=> resp_valid, "response dropped")
	`SISI_CHECK(a_count_cap, resp_valid |-> resp_count <= sisi_pkg::CNT_W'(CAPACITY), "count over capacity")
	`SISI_CHECK(a_single_last, resp_valid && resp_status != sisi_pkg::ST_ELEMENT |-> resp_last, "single result without last")
	`SISI_CHECK(a_insert_pos, resp_valid && resp_status == sisi_pkg::ST_INSERTED |-> resp_position < resp_count, "insert position past count")
	`SISI_CHECK(a_dump_order, resp_valid && resp_ready && resp_status == sisi_pkg::ST_ELEMENT && !resp_last |=> resp_valid && resp_status == sisi_pkg::ST_ELEMENT || !resp_valid, "dump interrupted")

endmodule

bind sorted_integer_set_insert sisi_checker #(
	.CAPACITY (CAPACITY)
) u_sisi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.resp_valid    (resp.valid),
	.resp_ready    (resp.ready),
	.resp_status   (resp.status),
	.resp_position (resp.position),
	.resp_count    (resp.count),
	.resp_last     (resp.last)
);

// ===== tb/sorted_integer_set_insert_checker.sv =====
// Checker that predicts the sorted set results and compares them with the block.
module sorted_set_checker #(
	parameter int CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	sisi_req_if                        req,
	sisi_resp_if                       resp,
	input  logic                       cfg_we,
	input  logic [sisi_pkg::VAL_W-1:0] cfg_wdata,
	output int                         fail_count,
	output int                         pending,
	output int                         results_seen,
	output int                         full_seen,
	output int                         range_seen
);
	import sisi_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  element;
		logic [CNT_W-1:0]  position;
		logic [CNT_W-1:0]  count;
		logic              last;
	} set_result_t;

	logic [VAL_W-1:0] model_vals [CAPACITY];
	int               model_size;
	logic [VAL_W-1:0] model_bound;
	set_result_t      awaited [$];

	function automatic set_result_t make_result(input logic [STAT_W-1:0] status,
		input logic [VAL_W-1:0] element, input int position, input int count,
		input logic last);
		set_result_t r;
		r.status   = status;
		r.element  = element;
		r.position = CNT_W'(position);
		r.count    = CNT_W'(count);
		r.last     = last;
		return r;
	endfunction

	task automatic predict_request(input logic op, input logic [VAL_W-1:0] v);
		int slot;
		slot = 0;
		if (op == OP_DUMP) begin
			if (model_size == 0) begin
				awaited.push_back(make_result(ST_EMPTY, '0, 0, 0, 1'b1));
			end else begin
				for (int j = 0; j < model_size; j++)
					awaited.push_back(make_result(ST_ELEMENT, model_vals[j], j, model_size,
						j + 1 == model_size));
			end
		end else begin
			while (slot < model_size && model_vals[slot] < v)
				slot++;
			if (v >= model_bound) begin
				awaited.push_back(make_result(ST_RANGE, v, slot, model_size, 1'b1));
			end else if (slot < model_size && model_vals[slot] == v) begin
				awaited.push_back(make_result(ST_PRESENT, v, slot, model_size, 1'b1));
			end else if (model_size >= CAPACITY) begin
				awaited.push_back(make_result(ST_FULL, v, slot, model_size, 1'b1));
			end else begin
				for (int j = model_size; j > slot; j--)
					model_vals[j] = model_vals[j-1];
				model_vals[slot] = v;
				model_size++;
				awaited.push_back(make_result(ST_INSERTED, v, slot, model_size, 1'b1));
			end
		end
	endtask

	task automatic compare_field(input string name, input int expd, input int got);
		if (expd != got) begin
			fail_count++;
			if (fail_count <= 100)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expd, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		set_result_t want;
		if (!arst_n) begin
			awaited.delete();
			model_size   = 0;
			model_bound  = '1;
			fail_count   = 0;
			pending      = 0;
			results_seen = 0;
			full_seen    = 0;
			range_seen   = 0;
		end else begin
			if (cfg_we)
				model_bound = cfg_wdata;
			if (resp.valid && resp.ready) begin
				results_seen++;
				if (awaited.size() == 0) begin
					fail_count++;
					if (fail_count <= 100)
						$display("%0t: unexpected result, expected none, actual status %0d element %0d",
							$time, resp.status, resp.element);
				end else begin
					want = awaited.pop_front();
					if (want.status == ST_FULL)
						full_seen++;
					if (want.status == ST_RANGE)
						range_seen++;
					compare_field("status", want.status, resp.status);
					compare_field("element", want.element, resp.element);
					compare_field("position", want.position, resp.position);
					compare_field("count", want.count, resp.count);
					compare_field("last", want.last, resp.last);
				end
			end
			if (req.valid && req.ready)
				predict_request(req.opcode, req.value);
			pending = awaited.size();
		end
	end

endmodule

// ===== tb/sorted_integer_set_insert_tb.sv =====
// Testbench top of the sorted integer set: request stimulus, receiver stalls and verdict.
module sorted_integer_set_insert_tb;
	import sisi_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 50;
	localparam int HOLD_CYCLES = 150;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [VAL_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;
	int               results_seen;
	int               full_seen;
	int               range_seen;
	int               cycles = 0;
	int               requests_sent = 0;
	int               settings_used = 0;
	int               hold_left = 0;
	logic             calm = 1'b0;
	logic             squeeze = 1'b0;
	logic             squeeze_done = 1'b0;
	logic [VAL_W-1:0] bound;
	logic [VAL_W-1:0] tried_vals [$];

	sisi_req_if  req_ch ();
	sisi_resp_if resp_ch ();

	sorted_integer_set_insert #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.resp      (resp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	sorted_set_checker #(
		.CAPACITY(CAPACITY)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.resp         (resp_ch),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.full_seen    (full_seen),
		.range_seen   (range_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			resp_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (squeeze && !squeeze_done) begin
			resp_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			squeeze_done <= 1'b1;
		end else begin
			resp_ch.ready <= calm || ($urandom_range(99) >= 20);
		end
	end

	task automatic offer(input logic op, input logic [VAL_W-1:0] v);
		int gap;
		gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(3, 1) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.value <= v;
		if (op == OP_INSERT)
			tried_vals.push_back(v);
		requests_sent++;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (CAPACITY + 4) @(negedge clk);
	endtask

	task automatic write_bound(input logic [VAL_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		bound = v;
		settings_used++;
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		int               roll;
		logic [VAL_W-1:0] v;
		roll = $urandom_range(99);
		v = VAL_W'($urandom);
		if (roll < 25 && tried_vals.size() > 0)
			v = tried_vals[$urandom_range(tried_vals.size() - 1)];
		else if (roll < 40)
			v = bound + VAL_W'($urandom_range(2)) - VAL_W'(1);
		else if (roll < 50)
			v = $urandom_range(1) ? '1 : '0;
		else if (roll < 70)
			v = VAL_W'($urandom_range(bound));
		return v;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_INSERT;
		req_ch.value = '0;
		resp_ch.ready = 1'b0;
		bound = '1;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		offer(OP_DUMP, '0);
		offer(OP_INSERT, 16'hFFFF);
		offer(OP_INSERT, 16'd0);
		offer(OP_INSERT, 16'hFFFE);
		offer(OP_INSERT, 16'd0);
		offer(OP_INSERT, 16'd100);
		offer(OP_INSERT, 16'hFFFE);
		offer(OP_DUMP, 16'hFFFF);
		drain();
		write_bound('0);
		offer(OP_INSERT, 16'd0);
		offer(OP_INSERT, 16'd50);
		offer(OP_DUMP, '0);
		drain();
		write_bound(16'd1000);
		offer(OP_INSERT, 16'd999);
		offer(OP_INSERT, 16'd1000);
		offer(OP_INSERT, 16'd500);
		offer(OP_DUMP, '0);

		for (int phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				0: write_bound('1);
				1: write_bound(VAL_W'($urandom_range(65534, 2)));
				2: write_bound(16'd1);
				3: write_bound(VAL_W'($urandom));
				4: write_bound('1);
				default: write_bound(VAL_W'($urandom_range(2000, 100)));
			endcase
			calm <= (phase == 4);
			squeeze <= (phase == 1);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(99) < 10)
					offer(OP_DUMP, VAL_W'($urandom));
				else
					offer(OP_INSERT, pick_value());
			end
		end
		drain();

		$display("Checked %0d results from %0d requests under %0d bound settings.",
			results_seen, requests_sent, settings_used);
		$display("Seen %0d full rejects and %0d out-of-range rejects, with one long receiver stall.",
			full_seen, range_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
